// ===== rtl/mfsgd_pkg.sv =====
// ============================================================================
// Biased matrix factorization SGD package
// Shared constants, codes and types for the rating predictor and trainer.
// ============================================================================
`default_nettype none

package mfsgd_pkg;

    // Table sizes. The row counts match the 10-bit id fields.
    localparam int USER_COUNT     = 1024;
    localparam int ITEM_COUNT     = 1024;
    localparam int ROW_COUNT      = (USER_COUNT > ITEM_COUNT) ? USER_COUNT : ITEM_COUNT;
    localparam int ROW_CNT_W      = $clog2(ROW_COUNT);
    localparam int FACTOR_DEFAULT = 16;

    // Q3.12 constants.
    localparam int Q_ONE    = 4096;
    localparam int PRED_MIN = 4096;
    localparam int PRED_MAX = 20480;

    // Depth of the update pipeline from request to write beat.
    localparam int UPD_DEPTH = 4;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_TRAIN     = 2'd0,
        OP_PREDICT   = 2'd1,
        OP_LOAD_USER = 2'd2,
        OP_LOAD_ITEM = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GLOBAL_MEAN   = 3'd0;
    localparam logic [2:0] CFG_BIAS_RATE     = 3'd1;
    localparam logic [2:0] CFG_BIAS_REG      = 3'd2;
    localparam logic [2:0] CFG_FACTOR_RATE   = 3'd3;
    localparam logic [2:0] CFG_FACTOR_REG    = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DOT,
        ST_DOT_WAIT,
        ST_PRED,
        ST_UPD,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control of one element moving through the update pipeline.
    typedef struct packed {
        logic valid;
        logic is_item;
        logic is_bias;
    } upd_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mfsgd_ram.sv =====
// ============================================================================
// Factor and bias row memory
// Simple dual-port synchronous RAM, one write and one registered read.
// ============================================================================
`default_nettype none

module mfsgd_ram
    import mfsgd_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic signed [15:0]  wdata,
    input  wire logic                re,
    input  wire logic [ADDR_W-1:0]   raddr,
    output logic signed [15:0]       rdata
);

    logic signed [15:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mfsgd_upd.sv =====
// ============================================================================
// SGD update pipeline
// Four-stage regularized step w + rate*(g - reg*w) with saturation.
// ============================================================================
`default_nettype none

module mfsgd_upd
    import mfsgd_pkg::*;
#(
    parameter int ADDR_W = 10
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire upd_ctl_t            req,
    input  wire logic [ADDR_W-1:0]   addr,
    input  wire logic signed [15:0]  w,
    input  wire logic signed [15:0]  x,
    input  wire logic signed [15:0]  err,
    input  wire logic [15:0]         bias_rate,
    input  wire logic [15:0]         bias_reg,
    input  wire logic [15:0]         factor_rate,
    input  wire logic [15:0]         factor_reg,
    output upd_ctl_t                 wr,
    output logic [ADDR_W-1:0]        wr_addr,
    output logic signed [15:0]       wr_data
);

    upd_ctl_t                  ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic [ADDR_W-1:0]         addr1_reg, addr2_reg, addr3_reg, addr4_reg;
    logic signed [15:0]        w1_reg, w2_reg, w3_reg;
    logic signed [19:0]        g1_reg;
    logic signed [16:0]        r1_reg;
    logic signed [20:0]        t2_reg;
    logic signed [21:0]        m3_reg;
    logic signed [15:0]        s4_reg;

    logic signed [31:0]        gprod;
    logic signed [19:0]        g;
    logic [15:0]               reg_sel;
    logic signed [32:0]        rprod;
    logic [15:0]               rate_sel;
    logic signed [37:0]        mprod;
    logic signed [22:0]        sum;
    logic signed [15:0]        sat;

    // Stage one: gradient and regularization products.
    always_comb
    begin
        gprod   = err * x;
        g       = req.is_bias ? 20'(err) : gprod[31:12];
        reg_sel = req.is_bias ? bias_reg : factor_reg;
        rprod   = $signed({1'b0, reg_sel}) * w;
    end

    // Stage three: scale by the step size.
    always_comb
    begin
        rate_sel = ctl2_reg.is_bias ? bias_rate : factor_rate;
        mprod    = $signed({1'b0, rate_sel}) * t2_reg;
    end

    // Stage four: add and saturate to 16 bits.
    always_comb
    begin
        sum = 23'(w3_reg) + 23'(m3_reg);
        if (sum > 23'sd32767)
        begin
            sat = 16'sh7FFF;
        end
        else if (sum < -23'sd32768)
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = sum[15:0];
        end
    end

    // Control through the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= req;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    // Payload through the stages.
    always_ff @(posedge clk)
    begin
        addr1_reg <= addr;
        w1_reg    <= w;
        g1_reg    <= g;
        r1_reg    <= rprod[32:16];
        addr2_reg <= addr1_reg;
        w2_reg    <= w1_reg;
        t2_reg    <= 21'(g1_reg) - 21'(r1_reg);
        addr3_reg <= addr2_reg;
        w3_reg    <= w2_reg;
        m3_reg    <= mprod[37:16];
        addr4_reg <= addr3_reg;
        s4_reg    <= sat;
    end

    assign wr      = ctl4_reg;
    assign wr_addr = addr4_reg;
    assign wr_data = s4_reg;

endmodule

`default_nettype wire

// ===== rtl/biased_matrix_factorization_sgd.sv =====
// ============================================================================
// Biased matrix factorization SGD
// Predicts a clamped rating from biases and factor vectors and trains them.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  operation, ids, rating, factor load
// out       output     out_valid/out_stall  prediction, prediction_error
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time. The dot product reads one element pair a cycle from
// the single read port of each row memory; the update pass reads less
// often, since it feeds both elements of each pair through one update
// pipeline. After reset a clearing pass zeroes the biases of all
// ROW_COUNT (1024) rows; input stalls during it. A result waits in the
// output register while the next item is taken.
`default_nettype none

module biased_matrix_factorization_sgd
    import mfsgd_pkg::*;
#(
    parameter int FACTOR_COUNT = FACTOR_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic [9:0]         user_id,
    input  wire logic [9:0]         item_id,
    input  wire logic [2:0]         rating,
    input  wire logic               many_ratings,
    input  wire logic [3:0]         factor_index,
    input  wire logic signed [15:0] factor_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [14:0]             prediction,
    output logic signed [15:0]      prediction_error,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int STRIDE  = FACTOR_COUNT + 1;
    localparam int DEPTH   = ROW_COUNT * STRIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int K_W     = $clog2(STRIDE);
    localparam int ACC_W   = 33 + $clog2(FACTOR_COUNT);
    localparam int PRED_W  = ACC_W + 2;
    localparam int DRAIN_W = $clog2(UPD_DEPTH + 1);

    // Configuration registers.
    logic [14:0] mean_reg;
    logic [15:0] brate_reg, breg_reg, frate_reg, freg_reg;

    // Sequencer.
    state_t state_reg, state_next;
    logic [ROW_CNT_W-1:0] clr_row_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [K_W-1:0]       k_reg, pk_reg, rk_reg;
    logic                 ph_reg, item_pend_reg, dot_rd_reg, prod_vld_reg;
    logic [DRAIN_W-1:0]   drain_reg;

    // Item fields.
    op_t                  op_reg;
    logic [ADDR_W-1:0]    ubase_reg, ibase_reg;
    logic [2:0]           rating_reg;
    logic                 many_reg;
    logic [3:0]           fidx_reg;
    logic signed [15:0]   fval_reg;

    // Datapath.
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      ubias_reg, ibias_reg;
    logic [14:0]             pred_reg;
    logic signed [15:0]      err_reg;
    logic                    out_valid_reg;
    logic [14:0]             out_pred_reg;
    logic signed [15:0]      out_err_reg;

    // Memory ports.
    logic               u_we, i_we, rd_en;
    logic [ADDR_W-1:0]  u_waddr, i_waddr, u_raddr, i_raddr;
    logic signed [15:0] u_wdata, i_wdata, u_rdata, i_rdata;

    // Update pipeline ports.
    upd_ctl_t           upd_req, upd_wr;
    logic [ADDR_W-1:0]  upd_addr, upd_wr_addr;
    logic signed [15:0] upd_w, upd_x, upd_wr_data;

    logic in_beat, load_ok, k_last, pk_bias;
    logic signed [PRED_W-1:0] pred_sum;
    logic [14:0] pred_clamp;

    assign in_beat   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign k_last    = (k_reg == K_W'(FACTOR_COUNT));
    assign pk_bias   = (pk_reg == K_W'(FACTOR_COUNT));
    assign load_ok   = (9'(fidx_reg) < 9'(FACTOR_COUNT));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            brate_reg <= '0;
            breg_reg  <= '0;
            frate_reg <= '0;
            freg_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GLOBAL_MEAN: mean_reg  <= cfg_data[14:0];
                CFG_BIAS_RATE:   brate_reg <= cfg_data;
                CFG_BIAS_REG:    breg_reg  <= cfg_data;
                CFG_FACTOR_RATE: frate_reg <= cfg_data;
                CFG_FACTOR_REG:  freg_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_row_reg == ROW_CNT_W'(ROW_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op_t'(operation) inside {OP_LOAD_USER, OP_LOAD_ITEM})
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_DOT;
                    end
                end
            end
            ST_LOAD:     state_next = ST_DONE;
            ST_DOT:
            begin
                if (k_last)
                begin
                    state_next = ST_DOT_WAIT;
                end
            end
            ST_DOT_WAIT: state_next = ST_PRED;
            ST_PRED:     state_next = (op_reg == OP_TRAIN) ? ST_UPD : ST_DONE;
            ST_UPD:
            begin
                if (ph_reg && k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == DRAIN_W'(UPD_DEPTH))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer control counters and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg   <= '0;
            clr_addr_reg  <= ADDR_W'(FACTOR_COUNT);
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            item_pend_reg <= 1'b0;
            dot_rd_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            drain_reg     <= '0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_row_reg  <= clr_row_reg + 1'b1;
                clr_addr_reg <= clr_addr_reg + ADDR_W'(STRIDE);
            end
            if (in_beat)
            begin
                k_reg <= many_ratings ? '0 : K_W'(FACTOR_COUNT);
            end
            else if (state_reg == ST_DOT && !k_last)
            begin
                k_reg <= k_reg + 1'b1;
            end
            else if (state_reg == ST_PRED)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_UPD && ph_reg && !k_last)
            begin
                k_reg <= k_reg + 1'b1;
            end
            ph_reg        <= (state_reg == ST_UPD) ? !ph_reg : 1'b0;
            item_pend_reg <= (state_reg == ST_UPD) && ph_reg;
            dot_rd_reg    <= (state_reg == ST_DOT);
            prod_vld_reg  <= dot_rd_reg && (rk_reg != K_W'(FACTOR_COUNT));
            drain_reg     <= (state_reg == ST_DRAIN) ? drain_reg + 1'b1 : '0;
        end
    end

    // Item capture, dot product and bias capture.
    always_ff @(posedge clk)
    begin
        pk_reg   <= k_reg;
        rk_reg   <= k_reg;
        prod_reg <= u_rdata * i_rdata;
        if (in_beat)
        begin
            op_reg     <= op_t'(operation);
            ubase_reg  <= ADDR_W'(user_id) * ADDR_W'(STRIDE);
            ibase_reg  <= ADDR_W'(item_id) * ADDR_W'(STRIDE);
            rating_reg <= rating;
            many_reg   <= many_ratings;
            fidx_reg   <= factor_index;
            fval_reg   <= factor_value;
            acc_reg    <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (dot_rd_reg && (rk_reg == K_W'(FACTOR_COUNT)))
        begin
            ubias_reg <= u_rdata;
            ibias_reg <= i_rdata;
        end
    end

    // Prediction, clamp and error.
    always_comb
    begin
        pred_sum = PRED_W'($signed({1'b0, mean_reg})) + PRED_W'(ubias_reg)
                 + PRED_W'(ibias_reg);
        if (many_reg)
        begin
            pred_sum = pred_sum + PRED_W'(acc_reg >>> 12);
        end
        if (pred_sum < PRED_W'(PRED_MIN))
        begin
            pred_clamp = 15'(PRED_MIN);
        end
        else if (pred_sum > PRED_W'(PRED_MAX))
        begin
            pred_clamp = 15'(PRED_MAX);
        end
        else
        begin
            pred_clamp = pred_sum[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRED)
        begin
            pred_reg <= pred_clamp;
            err_reg  <= $signed({1'b0, rating_reg, 12'b0}) - $signed({1'b0, pred_clamp});
        end
        else if (state_reg == ST_LOAD)
        begin
            pred_reg <= '0;
            err_reg  <= '0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!out_valid_reg || !out_stall))
        begin
            out_pred_reg <= pred_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign prediction       = out_pred_reg;
    assign prediction_error = out_err_reg;

    // Memory reads: one element pair per cycle in the dot pass; in the update
    // pass only while ph_reg is low.
    always_comb
    begin
        rd_en   = (state_reg == ST_DOT) || (state_reg == ST_UPD && !ph_reg);
        u_raddr = ubase_reg + ADDR_W'(k_reg);
        i_raddr = ibase_reg + ADDR_W'(k_reg);
    end

    // Update requests: the user element follows the read data, the item
    // element goes in the cycle after it, while the read data still holds.
    always_comb
    begin
        upd_req  = '0;
        upd_addr = u_raddr;
        upd_w    = u_rdata;
        upd_x    = i_rdata;
        if (state_reg == ST_UPD && ph_reg)
        begin
            upd_req.valid   = 1'b1;
            upd_req.is_bias = k_last;
        end
        else if (item_pend_reg)
        begin
            upd_req.valid   = 1'b1;
            upd_req.is_item = 1'b1;
            upd_req.is_bias = pk_bias;
            upd_addr        = ibase_reg + ADDR_W'(pk_reg);
            upd_w           = i_rdata;
            upd_x           = u_rdata;
        end
    end

    // Memory writes: clearing pass, factor loads and update write-back.
    always_comb
    begin
        u_we    = 1'b0;
        i_we    = 1'b0;
        u_waddr = upd_wr_addr;
        i_waddr = upd_wr_addr;
        u_wdata = upd_wr_data;
        i_wdata = upd_wr_data;
        if (state_reg == ST_CLEAR)
        begin
            u_we    = (32'(clr_row_reg) < 32'(USER_COUNT));
            i_we    = (32'(clr_row_reg) < 32'(ITEM_COUNT));
            u_waddr = clr_addr_reg;
            i_waddr = clr_addr_reg;
            u_wdata = '0;
            i_wdata = '0;
        end
        else if (state_reg == ST_LOAD)
        begin
            u_we    = load_ok && (op_reg == OP_LOAD_USER);
            i_we    = load_ok && (op_reg == OP_LOAD_ITEM);
            u_waddr = ubase_reg + ADDR_W'(fidx_reg);
            i_waddr = ibase_reg + ADDR_W'(fidx_reg);
            u_wdata = fval_reg;
            i_wdata = fval_reg;
        end
        else
        begin
            u_we = upd_wr.valid && !upd_wr.is_item;
            i_we = upd_wr.valid && upd_wr.is_item;
        end
    end

    mfsgd_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (rd_en),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    mfsgd_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_item_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .re    (rd_en),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    mfsgd_upd #(.ADDR_W(ADDR_W)) u_upd (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (upd_req),
        .addr        (upd_addr),
        .w           (upd_w),
        .x           (upd_x),
        .err         (err_reg),
        .bias_rate   (brate_reg),
        .bias_reg    (breg_reg),
        .factor_rate (frate_reg),
        .factor_reg  (freg_reg),
        .wr          (upd_wr),
        .wr_addr     (upd_wr_addr),
        .wr_data     (upd_wr_data)
    );

    // Write-back only happens while a train item is in its update passes.
    a_wr_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        upd_wr.valid |-> (state_reg == ST_UPD || state_reg == ST_DRAIN))
        else $error("update write outside the update passes");

    // A new result is only launched from the done state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

    // The update pipeline is empty whenever a new item can enter.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!upd_wr.valid && !item_pend_reg))
        else $error("update still in flight at idle");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ============================================================================
// Testbench for the biased matrix factorization SGD block
// Runs a directed table and then random rating traffic with factor loads.
// Every result beat is checked against a cycle-free predictor of the block,
// or for typed table rows against the values given in the table.
`timescale 1ns / 1ps
`default_nettype none

module tb_top
    import mfsgd_pkg::*;
();

    localparam int FACTORS     = FACTOR_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1050;
    localparam int SETTLE      = 120;

    typedef struct packed {
        logic [14:0]        pred;
        logic signed [15:0] err;
    } rating_result_t;

    typedef struct {
        op_t op;
        int  uid;
        int  iid;
        int  rating;
        int  many;
        int  fidx;
        int  fval;
        bit  typed;
        int  pred;
        int  err;
    } table_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          operation = OP_PREDICT;
    logic [9:0]          user_id = '0;
    logic [9:0]          item_id = '0;
    logic [2:0]          rating = '0;
    logic                many_ratings = 1'b0;
    logic [3:0]          factor_index = '0;
    logic signed [15:0]  factor_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [14:0]         prediction;
    logic signed [15:0]  prediction_error;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [15:0]         cfg_data = '0;

    // Predictor state and configuration.
    logic [14:0]        mean_q;
    logic [15:0]        bias_rate, bias_decay, factor_rate, factor_decay;
    logic signed [15:0] user_bias_m [USER_COUNT];
    logic signed [15:0] item_bias_m [ITEM_COUNT];
    logic signed [15:0] user_vec_m [USER_COUNT*FACTORS];
    logic signed [15:0] item_vec_m [ITEM_COUNT*FACTORS];

    rating_result_t pending_results [$];
    int ready_users [$];
    int ready_items [$];
    int fail_count = 0;
    int items_sent = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    biased_matrix_factorization_sgd dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .user_id          (user_id),
        .item_id          (item_id),
        .rating           (rating),
        .many_ratings     (many_ratings),
        .factor_index     (factor_index),
        .factor_value     (factor_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .prediction       (prediction),
        .prediction_error (prediction_error),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // One regularized SGD step with saturation to 16 bits.
    function automatic logic signed [15:0] sgd_update(logic signed [15:0] wt, longint grad,
                                                      logic [15:0] rate, logic [15:0] decay);
        longint tmp;
        longint upd;
        tmp = grad - ((longint'(decay) * longint'(wt)) >>> 16);
        upd = longint'(wt) + ((longint'(rate) * tmp) >>> 16);
        if (upd > 32767)
            upd = 32767;
        if (upd < -32768)
            upd = -32768;
        return upd[15:0];
    endfunction

    // Computes the result of one input beat and applies its state changes.
    function automatic rating_result_t rate_and_train(op_t op, int uid, int iid, int rt,
                                                      int many, int fidx, int fval);
        rating_result_t res;
        longint pred;
        longint err;
        longint acc;
        logic signed [15:0] pk, qk;
        int ub;
        int ib;
        res = '0;
        ub = uid * FACTORS;
        ib = iid * FACTORS;
        if (op == OP_LOAD_USER)
        begin
            user_vec_m[ub + fidx] = fval[15:0];
            return res;
        end
        if (op == OP_LOAD_ITEM)
        begin
            item_vec_m[ib + fidx] = fval[15:0];
            return res;
        end
        pred = longint'(mean_q) + longint'(user_bias_m[uid]) + longint'(item_bias_m[iid]);
        if (many != 0)
        begin
            acc = 0;
            for (int k = 0; k < FACTORS; k++)
                acc += longint'(user_vec_m[ub + k]) * longint'(item_vec_m[ib + k]);
            pred += acc >>> 12;
        end
        if (pred < PRED_MIN)
            pred = PRED_MIN;
        if (pred > PRED_MAX)
            pred = PRED_MAX;
        err = longint'(rt) * Q_ONE - pred;
        if (op == OP_TRAIN)
        begin
            user_bias_m[uid] = sgd_update(user_bias_m[uid], err, bias_rate, bias_decay);
            item_bias_m[iid] = sgd_update(item_bias_m[iid], err, bias_rate, bias_decay);
            for (int k = 0; k < FACTORS; k++)
            begin
                pk = user_vec_m[ub + k];
                qk = item_vec_m[ib + k];
                user_vec_m[ub + k] = sgd_update(pk, (err * longint'(qk)) >>> 12,
                                                factor_rate, factor_decay);
                item_vec_m[ib + k] = sgd_update(qk, (err * longint'(pk)) >>> 12,
                                                factor_rate, factor_decay);
            end
        end
        res.pred = pred[14:0];
        res.err  = err[15:0];
        return res;
    endfunction

    // Sends one input beat, with random sender gaps, and records its result.
    task automatic send_rating(op_t op, int uid, int iid, int rt, int many, int fidx,
                               int fval, bit typed = 0, int tpred = 0, int terr = 0);
        rating_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        user_id      <= uid[9:0];
        item_id      <= iid[9:0];
        rating       <= rt[2:0];
        many_ratings <= many[0];
        factor_index <= fidx[3:0];
        factor_value <= fval[15:0];
        do
            @(posedge clk);
        while (in_stall);
        res = rate_and_train(op, uid, iid, rt, many, fidx, fval);
        if (typed)
        begin
            res.pred = tpred[14:0];
            res.err  = terr[15:0];
        end
        pending_results.push_back(res);
        items_sent++;
    endtask

    // Loads a whole factor vector, mostly with small values.
    task automatic load_vector(bit is_item, int row);
        int val;
        for (int k = 0; k < FACTORS; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                val = $signed(16'($urandom));
            else
                val = $urandom_range(0, 8191) - 4096;
            send_rating(is_item ? OP_LOAD_ITEM : OP_LOAD_USER, is_item ? 0 : row,
                        is_item ? row : 0, 0, 0, k, val);
        end
        if (is_item)
            ready_items.push_back(row);
        else
            ready_users.push_back(row);
    endtask

    // Waits until the block has drained, then writes every register.
    task automatic program_registers(logic [15:0] vals [5]);
        logic [2:0] regs [5];
        regs = '{CFG_GLOBAL_MEAN, CFG_BIAS_RATE, CFG_BIAS_REG, CFG_FACTOR_RATE,
                 CFG_FACTOR_REG};
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (regs[i])
                CFG_GLOBAL_MEAN: mean_q       = vals[i][14:0];
                CFG_BIAS_RATE:   bias_rate    = vals[i];
                CFG_BIAS_REG:    bias_decay   = vals[i];
                CFG_FACTOR_RATE: factor_rate  = vals[i];
                CFG_FACTOR_REG:  factor_decay = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // One random step: noise loads, single-rating trains and predicts, or rating
    // traffic on users and items whose factor vectors are fully loaded.
    task automatic random_step();
        int pick;
        int uid;
        int iid;
        int rt;
        pick = $urandom_range(0, 99);
        rt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
        if (pick < 12)
        begin
            uid = $urandom_range(0, 1023);
            iid = $urandom_range(0, 1023);
            send_rating($urandom_range(0, 1) ? OP_LOAD_ITEM : OP_LOAD_USER, uid, iid,
                        $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 15),
                        $signed(16'($urandom)));
        end
        else if (pick < 20)
            send_rating($urandom_range(0, 1) ? OP_TRAIN : OP_PREDICT, 0, 0, rt, 0, 0, 0,
                        0);
        else
        begin
            if (ready_users.size() < 6 || $urandom_range(0, 39) == 0)
                load_vector(0, $urandom_range(0, 1023));
            if (ready_items.size() < 6 || $urandom_range(0, 39) == 0)
                load_vector(1, $urandom_range(0, 1023));
            uid = ready_users[$urandom_range(0, ready_users.size() - 1)];
            iid = ready_items[$urandom_range(0, ready_items.size() - 1)];
            send_rating(($urandom_range(0, 9) < 7) ? OP_TRAIN : OP_PREDICT, uid, iid, rt,
                        $urandom_range(0, 1), $urandom_range(0, 15),
                        $signed(16'($urandom)));
        end
    endtask

    // Result side: random stall and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        rating_result_t exp_res;
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: prediction %0d", prediction);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (prediction !== exp_res.pred)
                begin
                    $error("prediction: expected %0d, got %0d", exp_res.pred, prediction);
                    fail_count++;
                end
                if (prediction_error !== exp_res.err)
                begin
                    $error("prediction_error: expected %0d, got %0d", exp_res.err,
                           prediction_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        table_row_t rows [$];
        logic [15:0] vals [5];
        mean_q = '0;
        bias_rate = '0;
        bias_decay = '0;
        factor_rate = '0;
        factor_decay = '0;
        foreach (user_bias_m[i])
            user_bias_m[i] = '0;
        foreach (item_bias_m[i])
            item_bias_m[i] = '0;
        foreach (user_vec_m[i])
            user_vec_m[i] = '0;
        foreach (item_vec_m[i])
            item_vec_m[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration: zero mean, zero rates.
        rows = '{
            '{OP_PREDICT,   0,    0,    5, 0, 0,  0,      1, 4096, 16384},
            '{OP_PREDICT,   1023, 1023, 0, 0, 0,  0,      1, 4096, -4096},
            '{OP_PREDICT,   512,  7,    7, 0, 15, -1,     1, 4096, 24576},
            '{OP_LOAD_USER, 1023, 0,    0, 0, 15, -32768, 1, 0,    0},
            '{OP_LOAD_ITEM, 0,    1023, 7, 1, 0,  32767,  1, 0,    0},
            '{OP_PREDICT,   0,    0,    5, 1, 0,  0,      0, 0,    0},
            '{OP_LOAD_USER, 0,    0,    1, 0, 0,  32767,  1, 0,    0},
            '{OP_LOAD_ITEM, 0,    0,    1, 0, 0,  32767,  1, 0,    0},
            '{OP_PREDICT,   0,    0,    5, 1, 0,  0,      0, 0,    0},
            '{OP_TRAIN,     0,    0,    1, 1, 0,  0,      0, 0,    0},
            '{OP_LOAD_USER, 0,    0,    0, 0, 0,  -32768, 1, 0,    0},
            '{OP_PREDICT,   0,    0,    1, 1, 0,  0,      0, 0,    0},
            '{OP_TRAIN,     0,    0,    3, 0, 0,  0,      0, 0,    0},
            '{OP_LOAD_ITEM, 0,    0,    0, 0, 1,  -32768, 1, 0,    0},
            '{OP_TRAIN,     0,    0,    7, 1, 0,  0,      0, 0,    0},
            '{OP_PREDICT,   0,    0,    0, 1, 0,  0,      0, 0,    0}
        };
        load_vector(0, 0);
        load_vector(1, 0);
        foreach (rows[i])
            send_rating(rows[i].op, rows[i].uid, rows[i].iid, rows[i].rating, rows[i].many,
                        rows[i].fidx, rows[i].fval, rows[i].typed, rows[i].pred,
                        rows[i].err);

        // Random phases, each with its own register setting and idling mix.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: vals = '{16'd14000, 16'd3000, 16'd600, 16'd2000, 16'd400};
                1: vals = '{16'd20480, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                default: vals = '{16'($urandom_range(0, 20480)), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            program_registers(vals);
            send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 24 : 0;
            recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 24 : 0;
            while (items_sent < ITEM_TARGET * (phase + 1) / 4)
                random_step();
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
